/* sv/tnd_pkg.sv */
// Shared types and constants for the thumbnail nearest-neighbor downscaler.
// No dependencies; imported by every module of the block.
`default_nettype none

package tnd_pkg;

  localparam int MAX_SIDE        = 4096;
  localparam int BYTES_PER_PIXEL = 4;

  localparam int SIDE_W    = $clog2(MAX_SIDE) + 1;   // side lengths 0..MAX_SIDE (13)
  localparam int COORD_W   = $clog2(MAX_SIDE);       // thumbnail coordinates (12)
  localparam int PIX_W     = 32;
  localparam int BYTES_W   = 27;
  localparam int PROD_W    = 2 * SIDE_W;
  localparam int BPP_SHIFT = $clog2(BYTES_PER_PIXEL);
  localparam int AREA_W    = PROD_W + BPP_SHIFT;
  localparam int DIV_NUM_W = 2 * COORD_W;            // side * edge limit + edge/2 fits here
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = BYTES_W;

  localparam logic [SIDE_W-1:0]  MAX_EDGE_RST  = SIDE_W'(256);
  localparam logic [BYTES_W-1:0] MAX_BYTES_RST = BYTES_W'(262144);
  localparam logic [SIDE_W-1:0]  MAX_SIDE_VAL  = SIDE_W'(MAX_SIDE);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = CFG_IDX_W'(0),
    REG_SOURCE_HEIGHT = CFG_IDX_W'(1),
    REG_MAX_EDGE      = CFG_IDX_W'(2),
    REG_MAX_BYTES     = CFG_IDX_W'(3)
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MS_WIDTH,
    MS_HEIGHT,
    MS_AREA
  } mul_sel_t;

  typedef enum logic [1:0] {
    DS_WIDTH,
    DS_HEIGHT,
    DS_COL,
    DS_ROW
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_W,
    ST_LD_W,
    ST_DV_W,
    ST_MUL_H,
    ST_LD_H,
    ST_DV_H,
    ST_AREA,
    ST_CHECK,
    ST_LD_C,
    ST_DV_C,
    ST_LD_R,
    ST_DV_R
  } ctrl_state_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     bad_init;
    logic     area_check;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_latch;
    logic     fit_done;
    logic     pix_accept;
  } cmd_t;

  typedef struct packed {
    logic started;
    logic out_free;
    logic div_done;
    logic cfg_wr;
  } sts_t;

endpackage

`default_nettype wire

/* sv/tnd_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tnd_pkg for widths.
`default_nettype none

module tnd_div
  import tnd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [SIDE_W-1:0]    den,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quo,
  output logic [SIDE_W-1:0]         rem
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [SIDE_W-1:0]    rem_r, rem_nxt;
  logic [SIDE_W-1:0]    den_r, den_nxt;
  logic [SIDE_W:0]      trial;
  logic [SIDE_W:0]      diff;
  logic                 ge;

  always_comb begin
    trial    = {rem_r, num_r[DIV_NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W - 1);
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // dividend shifts out at the top, quotient bits shift in at the bottom
      num_nxt = {num_r[DIV_NUM_W-2:0], ge};
      rem_nxt = ge ? diff[SIDE_W-1:0] : trial[SIDE_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

/* sv/tnd_dpath.sv */
// Datapath: config registers, size fitting operands, pixel selection
// accumulators and the output register. Depends on tnd_pkg and tnd_div.
`default_nettype none

module tnd_dpath
  import tnd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire logic [PIX_W-1:0]     in_pixel,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_pixel,
  output logic [COORD_W-1:0]        out_column,
  output logic [COORD_W-1:0]        out_row,
  output logic [SIDE_W-1:0]         out_thumb_width,
  output logic [SIDE_W-1:0]         out_thumb_height,
  output logic                      out_frame_done,
  output logic                      out_status
);

  // configuration
  logic [SIDE_W-1:0]  sw_r, sw_nxt;
  logic [SIDE_W-1:0]  sh_r, sh_nxt;
  logic [SIDE_W-1:0]  me_r, me_nxt;
  logic [BYTES_W-1:0] mb_r, mb_nxt;
  logic               cfg_known;

  // frame fitting
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               bad_r, bad_nxt;
  logic [SIDE_W-1:0]  tw_r, tw_nxt;
  logic [SIDE_W-1:0]  th_r, th_nxt;
  logic [SIDE_W-1:0]  cq_r, cq_nxt;   // src width / thumb width
  logic [SIDE_W-1:0]  cr_r, cr_nxt;
  logic [SIDE_W-1:0]  rq_r, rq_nxt;   // src height / thumb height
  logic [SIDE_W-1:0]  rr_r, rr_nxt;
  logic               started_r, started_nxt;
  logic               first_r, first_nxt;

  // per-pixel position tracking
  logic [SIDE_W-1:0]  col_in_r, col_in_nxt;
  logic [SIDE_W-1:0]  row_in_r, row_in_nxt;
  logic [SIDE_W-1:0]  ncol_r, ncol_nxt;
  logic [SIDE_W-1:0]  nrow_r, nrow_nxt;
  logic [SIDE_W-1:0]  ctgt_r, ctgt_nxt;
  logic [SIDE_W-1:0]  rtgt_r, rtgt_nxt;
  logic [SIDE_W-1:0]  crem_r, crem_nxt;
  logic [SIDE_W-1:0]  rrem_r, rrem_nxt;

  // output register
  logic               ov_r, ov_nxt;
  logic [PIX_W-1:0]   opix_r, opix_nxt;
  logic [COORD_W-1:0] ocol_r, ocol_nxt;
  logic [COORD_W-1:0] orow_r, orow_nxt;
  logic [SIDE_W-1:0]  otw_r, otw_nxt;
  logic [SIDE_W-1:0]  oth_r, oth_nxt;
  logic               odone_r, odone_nxt;
  logic               ostat_r, ostat_nxt;

  // combinational helpers
  logic [SIDE_W-1:0]    edge_len;
  logic [SIDE_W-1:0]    mul_a, mul_b;
  logic [DIV_NUM_W-1:0] div_num;
  logic [SIDE_W-1:0]    div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [SIDE_W-1:0]    div_rem;
  logic [SIDE_W-1:0]    quo_side;
  logic [SIDE_W-1:0]    fit_side;
  logic [AREA_W-1:0]    area_bytes;
  logic                 zero_side;
  logic                 row_hit;
  logic                 emit_px;
  logic [SIDE_W:0]      col_sum, row_sum;
  logic                 col_carry, row_carry;
  logic [SIDE_W:0]      col_in_inc, row_in_inc;

  assign edge_len  = (sw_r > sh_r) ? sw_r : sh_r;
  assign zero_side = (sw_r == '0) || (sh_r == '0);
  assign quo_side  = div_quo[SIDE_W-1:0];
  assign cfg_known = (cfg_index == REG_SOURCE_WIDTH) || (cfg_index == REG_SOURCE_HEIGHT) ||
                     (cfg_index == REG_MAX_EDGE) || (cfg_index == REG_MAX_BYTES);

  always_comb begin
    unique case (cmd.mul_sel)
      MS_WIDTH:  begin mul_a = sw_r; mul_b = me_r; end
      MS_HEIGHT: begin mul_a = sh_r; mul_b = me_r; end
      MS_AREA:   begin mul_a = tw_r; mul_b = th_r; end
      default:   begin mul_a = tw_r; mul_b = th_r; end
    endcase
  end

  always_comb begin
    unique case (cmd.div_sel)
      DS_WIDTH, DS_HEIGHT: begin
        // round half up: (side * edge limit + edge / 2) / edge
        div_num = prod_r[DIV_NUM_W-1:0] + DIV_NUM_W'(edge_len >> 1);
        div_den = edge_len;
      end
      DS_COL: begin
        div_num = DIV_NUM_W'(sw_r);
        div_den = tw_r;
      end
      default: begin
        div_num = DIV_NUM_W'(sh_r);
        div_den = th_r;
      end
    endcase
  end

  tnd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    // sides that already fit are kept; scaled sides never drop below one
    if (edge_len <= me_r) begin
      fit_side = (cmd.div_sel == DS_WIDTH) ? sw_r : sh_r;
    end else if (quo_side == '0) begin
      fit_side = SIDE_W'(1);
    end else begin
      fit_side = quo_side;
    end
  end

  assign area_bytes = AREA_W'(prod_r) << BPP_SHIFT;

  assign row_hit    = (row_in_r == rtgt_r) && (nrow_r < th_r);
  assign emit_px    = !bad_r && row_hit && (col_in_r == ctgt_r) && (ncol_r < tw_r);
  assign col_sum    = {1'b0, crem_r} + {1'b0, cr_r};
  assign col_carry  = (col_sum >= {1'b0, tw_r});
  assign row_sum    = {1'b0, rrem_r} + {1'b0, rr_r};
  assign row_carry  = (row_sum >= {1'b0, th_r});
  assign col_in_inc = {1'b0, col_in_r} + 1'b1;
  assign row_in_inc = {1'b0, row_in_r} + 1'b1;

  always_comb begin
    sw_nxt      = sw_r;
    sh_nxt      = sh_r;
    me_nxt      = me_r;
    mb_nxt      = mb_r;
    prod_nxt    = prod_r;
    bad_nxt     = bad_r;
    tw_nxt      = tw_r;
    th_nxt      = th_r;
    cq_nxt      = cq_r;
    cr_nxt      = cr_r;
    rq_nxt      = rq_r;
    rr_nxt      = rr_r;
    started_nxt = started_r;
    first_nxt   = first_r;
    col_in_nxt  = col_in_r;
    row_in_nxt  = row_in_r;
    ncol_nxt    = ncol_r;
    nrow_nxt    = nrow_r;
    ctgt_nxt    = ctgt_r;
    rtgt_nxt    = rtgt_r;
    crem_nxt    = crem_r;
    rrem_nxt    = rrem_r;
    ov_nxt      = ov_r && !out_ready;
    opix_nxt    = opix_r;
    ocol_nxt    = ocol_r;
    orow_nxt    = orow_r;
    otw_nxt     = otw_r;
    oth_nxt     = oth_r;
    odone_nxt   = odone_r;
    ostat_nxt   = ostat_r;

    if (cmd.mul_en) begin
      prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.bad_init) begin
      bad_nxt = zero_side || (me_r == '0) || (sw_r > MAX_SIDE_VAL) || (sh_r > MAX_SIDE_VAL);
    end
    if (cmd.area_check) begin
      bad_nxt = bad_r || (area_bytes > AREA_W'(mb_r));
    end
    if (cmd.div_latch) begin
      unique case (cmd.div_sel)
        DS_WIDTH:  tw_nxt = fit_side;
        DS_HEIGHT: th_nxt = fit_side;
        DS_COL:    begin cq_nxt = quo_side; cr_nxt = div_rem; end
        default:   begin rq_nxt = quo_side; rr_nxt = div_rem; end
      endcase
    end
    if (cmd.fit_done) begin
      started_nxt = 1'b1;
      first_nxt   = 1'b1;
      col_in_nxt  = '0;
      row_in_nxt  = '0;
      ncol_nxt    = '0;
      nrow_nxt    = '0;
      ctgt_nxt    = '0;
      rtgt_nxt    = '0;
      crem_nxt    = '0;
      rrem_nxt    = '0;
    end

    if (cmd.pix_accept) begin
      first_nxt = 1'b0;
      if (bad_r) begin
        if (first_r) begin
          ov_nxt    = 1'b1;
          opix_nxt  = '0;
          ocol_nxt  = '0;
          orow_nxt  = '0;
          otw_nxt   = '0;
          oth_nxt   = '0;
          odone_nxt = 1'b1;
          ostat_nxt = 1'b1;
        end
      end else if (emit_px) begin
        ov_nxt    = 1'b1;
        opix_nxt  = in_pixel;
        ocol_nxt  = ncol_r[COORD_W-1:0];
        orow_nxt  = nrow_r[COORD_W-1:0];
        otw_nxt   = tw_r;
        oth_nxt   = th_r;
        odone_nxt = ((ncol_r + 1'b1) == tw_r) && ((nrow_r + 1'b1) == th_r);
        ostat_nxt = 1'b0;
        ncol_nxt  = ncol_r + 1'b1;
        ctgt_nxt  = ctgt_r + cq_r + SIDE_W'(col_carry);
        crem_nxt  = col_carry ? SIDE_W'(col_sum - {1'b0, tw_r}) : col_sum[SIDE_W-1:0];
      end

      if (bad_r && zero_side) begin
        // a frame with an empty side is one pixel long
        started_nxt = 1'b0;
      end else if (col_in_inc >= {1'b0, sw_r}) begin
        col_in_nxt = '0;
        if (!bad_r && row_hit) begin
          nrow_nxt = nrow_r + 1'b1;
          rtgt_nxt = rtgt_r + rq_r + SIDE_W'(row_carry);
          rrem_nxt = row_carry ? SIDE_W'(row_sum - {1'b0, th_r}) : row_sum[SIDE_W-1:0];
          ncol_nxt = '0;
          ctgt_nxt = '0;
          crem_nxt = '0;
        end
        if (row_in_inc >= {1'b0, sh_r}) begin
          row_in_nxt  = '0;
          started_nxt = 1'b0;
        end else begin
          row_in_nxt = row_in_inc[SIDE_W-1:0];
        end
      end else begin
        col_in_nxt = col_in_inc[SIDE_W-1:0];
      end
    end

    // a write to any known register abandons the current frame
    if (cfg_valid && cfg_known) begin
      started_nxt = 1'b0;
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  sw_nxt = cfg_data[SIDE_W-1:0];
        REG_SOURCE_HEIGHT: sh_nxt = cfg_data[SIDE_W-1:0];
        REG_MAX_EDGE:      me_nxt = cfg_data[SIDE_W-1:0];
        default:           mb_nxt = cfg_data[BYTES_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r      <= '0;
      sh_r      <= '0;
      me_r      <= MAX_EDGE_RST;
      mb_r      <= MAX_BYTES_RST;
      started_r <= 1'b0;
      first_r   <= 1'b0;
      bad_r     <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      sw_r      <= sw_nxt;
      sh_r      <= sh_nxt;
      me_r      <= me_nxt;
      mb_r      <= mb_nxt;
      started_r <= started_nxt;
      first_r   <= first_nxt;
      bad_r     <= bad_nxt;
      ov_r      <= ov_nxt;
    end
    prod_r   <= prod_nxt;
    tw_r     <= tw_nxt;
    th_r     <= th_nxt;
    cq_r     <= cq_nxt;
    cr_r     <= cr_nxt;
    rq_r     <= rq_nxt;
    rr_r     <= rr_nxt;
    col_in_r <= col_in_nxt;
    row_in_r <= row_in_nxt;
    ncol_r   <= ncol_nxt;
    nrow_r   <= nrow_nxt;
    ctgt_r   <= ctgt_nxt;
    rtgt_r   <= rtgt_nxt;
    crem_r   <= crem_nxt;
    rrem_r   <= rrem_nxt;
    opix_r   <= opix_nxt;
    ocol_r   <= ocol_nxt;
    orow_r   <= orow_nxt;
    otw_r    <= otw_nxt;
    oth_r    <= oth_nxt;
    odone_r  <= odone_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign sts.started  = started_r;
  assign sts.out_free = !ov_r || out_ready;
  assign sts.div_done = div_done;
  assign sts.cfg_wr   = cfg_valid && cfg_known;

  assign out_valid        = ov_r;
  assign out_pixel        = opix_r;
  assign out_column       = ocol_r;
  assign out_row          = orow_r;
  assign out_thumb_width  = otw_r;
  assign out_thumb_height = oth_r;
  assign out_frame_done   = odone_r;
  assign out_status       = ostat_r;

endmodule

`default_nettype wire

/* sv/tnd_ctrl.sv */
// Controller: sequences the per-frame size fit and gates pixel transfers.
// Depends on tnd_pkg for state, command and status types.
`default_nettype none

module tnd_ctrl
  import tnd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.mul_sel    = MS_WIDTH;
    cmd.div_sel    = DS_WIDTH;
    in_ready       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready       = sts.started && sts.out_free;
        cmd.pix_accept = in_valid && in_ready;
        if (!sts.started && in_valid) begin
          state_nxt = ST_MUL_W;
        end
      end
      ST_MUL_W: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_WIDTH;
        cmd.bad_init = 1'b1;
        state_nxt    = ST_LD_W;
      end
      ST_LD_W: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_WIDTH;
        state_nxt     = ST_DV_W;
      end
      ST_DV_W: begin
        cmd.div_sel = DS_WIDTH;
        if (sts.div_done) begin
          cmd.div_latch = 1'b1;
          state_nxt     = ST_MUL_H;
        end
      end
      ST_MUL_H: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_HEIGHT;
        state_nxt   = ST_LD_H;
      end
      ST_LD_H: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_HEIGHT;
        state_nxt     = ST_DV_H;
      end
      ST_DV_H: begin
        cmd.div_sel = DS_HEIGHT;
        if (sts.div_done) begin
          cmd.div_latch = 1'b1;
          state_nxt     = ST_AREA;
        end
      end
      ST_AREA: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_AREA;
        state_nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.area_check = 1'b1;
        state_nxt      = ST_LD_C;
      end
      ST_LD_C: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_COL;
        state_nxt     = ST_DV_C;
      end
      ST_DV_C: begin
        cmd.div_sel = DS_COL;
        if (sts.div_done) begin
          cmd.div_latch = 1'b1;
          state_nxt     = ST_LD_R;
        end
      end
      ST_LD_R: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_ROW;
        state_nxt     = ST_DV_R;
      end
      ST_DV_R: begin
        cmd.div_sel = DS_ROW;
        if (sts.div_done) begin
          cmd.div_latch = 1'b1;
          cmd.fit_done  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a register write mid-fit restarts the fit from the new settings
    if (sts.cfg_wr && (state_r != ST_IDLE)) begin
      cmd         = '0;
      cmd.mul_sel = MS_WIDTH;
      cmd.div_sel = DS_WIDTH;
      state_nxt   = ST_IDLE;
    end
  end

endmodule

`default_nettype wire

/* sv/thumbnail_nearest_downscaler_core.sv */
// Thumbnail nearest-neighbor downscaler, top level. Depends on tnd_pkg, tnd_ctrl, tnd_dpath.
// Output: a selected pixel appears on the out_ port in the cycle after its input transfer.
// Throughput: one pixel per cycle inside a frame unless the output is held by out_ready.
// The first pixel of each frame waits for the size fit, four passes through the shared
// 24-step divider; a frame with an empty side fits again on every pixel.
// Reset: rst_n synchronous, active low; registers take their defaults, no frame is open.
`default_nettype none

module thumbnail_nearest_downscaler_core
  import tnd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [PIX_W-1:0]     in_pixel,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          out_pixel,
  output logic [COORD_W-1:0]        out_column,
  output logic [COORD_W-1:0]        out_row,
  output logic [SIDE_W-1:0]         out_thumb_width,
  output logic [SIDE_W-1:0]         out_thumb_height,
  output logic                      out_frame_done,
  output logic                      out_status,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  tnd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tnd_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_pixel         (in_pixel),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel        (out_pixel),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_thumb_width  (out_thumb_width),
    .out_thumb_height (out_thumb_height),
    .out_frame_done   (out_frame_done),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

/* verif/tb.sv */
// Testbench for thumbnail_nearest_downscaler_core: random RGBA frames under many size settings.
// Checks every output transfer against a cycle-free predictor of the nearest-neighbor pick.
// Depends on tnd_pkg and the core RTL only.
`default_nettype none

module tb;
  import tnd_pkg::*;

  localparam int          SETTLE_CYCLES = 200;     // covers the size fit
  localparam int          HOLD_CYCLES   = 600;
  localparam int          IDLE_PCT      = 31;
  localparam int          RANDOM_ITEMS  = 600;
  localparam int          LONG_RUN_PX   = 150;
  localparam int          CYCLE_LIMIT   = 2000000;
  localparam int unsigned MAX_BYTES_CFG = 67108864;
  localparam logic [CFG_DAT_W-1:0] UPPER_BITS  = 27'h7FFE000;  // above the 13-bit side field
  localparam logic [CFG_IDX_W-1:0] BAD_REG_IDX = 8'hA5;
  localparam logic STATUS_PIXEL  = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [SIDE_W-1:0]  width;
    logic [SIDE_W-1:0]  height;
    logic               done;
    logic               status;
  } thumb_px_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_pixel;
  logic [COORD_W-1:0]   out_column;
  logic [COORD_W-1:0]   out_row;
  logic [SIDE_W-1:0]    out_thumb_width;
  logic [SIDE_W-1:0]    out_thumb_height;
  logic                 out_frame_done;
  logic                 out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  thumbnail_nearest_downscaler_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel        (out_pixel),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_thumb_width  (out_thumb_width),
    .out_thumb_height (out_thumb_height),
    .out_frame_done   (out_frame_done),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [PIX_W-1:0] src_pixels[$];
  thumb_px_t        pending_thumb_px[$];
  bit               in_fire = 1'b0;
  int               mismatches = 0;
  int               cycles = 0;
  int               tx_idle_pct = IDLE_PCT;
  int               rx_idle_pct = IDLE_PCT;
  int               hold_req = 0;
  int               hold_seen = 0;
  int               hold_left = 0;

  // predictor copy of the registers and the frame walk
  int unsigned frame_w = 0, frame_h = 0, edge_cap = 256, byte_cap = 262144;
  int unsigned src_col = 0, src_row = 0, next_x = 0, next_y = 0;
  int unsigned pick_col = 0, pick_row = 0, thumb_w = 0, thumb_h = 0;
  bit          frame_bad = 1'b0, frame_open = 1'b0;

  // returns 1 when the frame must be rejected; tw/th are zero then
  function automatic bit fit_thumb(input int unsigned sw, sh, me, mb,
                                   output int unsigned tw, th);
    longint unsigned longer;
    bit bad;
    tw = 0;
    th = 0;
    bad = (sw == 0 || sh == 0 || me == 0 || sw > MAX_SIDE || sh > MAX_SIDE);
    if (!bad) begin
      longer = 64'((sw > sh) ? sw : sh);
      if (longer <= me) begin
        tw = sw;
        th = sh;
      end else begin
        tw = 32'((64'(sw) * me + longer / 2) / longer);
        th = 32'((64'(sh) * me + longer / 2) / longer);
        if (tw == 0) tw = 1;
        if (th == 0) th = 1;
      end
      if (64'(tw) * th * BYTES_PER_PIXEL > mb) bad = 1'b1;
    end
    if (bad) begin
      tw = 0;
      th = 0;
    end
    return bad;
  endfunction

  // source index picked for thumbnail index k: floor(k*src/thumb)
  function automatic int unsigned nearest_src(int unsigned k, src, thumb);
    return (thumb == 0) ? 0 : 32'(64'(k) * src / thumb);
  endfunction

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_SOURCE_WIDTH:  frame_w = 32'(data[SIDE_W-1:0]);
      REG_SOURCE_HEIGHT: frame_h = 32'(data[SIDE_W-1:0]);
      REG_MAX_EDGE:      edge_cap = 32'(data[SIDE_W-1:0]);
      REG_MAX_BYTES:     byte_cap = 32'(data);
      default:           return;
    endcase
    frame_open = 1'b0;
  endtask

  task automatic select_pixel(logic [PIX_W-1:0] px);
    thumb_px_t thumb;
    bit first;
    first = !frame_open;
    if (first) begin
      frame_bad = fit_thumb(frame_w, frame_h, edge_cap, byte_cap, thumb_w, thumb_h);
      src_col = 0;
      src_row = 0;
      next_x = 0;
      next_y = 0;
      pick_col = 0;
      pick_row = 0;
      frame_open = 1'b1;
    end
    if (frame_bad) begin
      if (first) begin
        thumb = '{pixel: '0, column: '0, row: '0, width: '0, height: '0,
                  done: 1'b1, status: STATUS_REJECT};
        pending_thumb_px.push_back(thumb);
      end
      // an empty side makes every pixel a frame of its own
      if (frame_w == 0 || frame_h == 0) begin
        frame_open = 1'b0;
        return;
      end
    end else if (src_row == pick_row && next_y < thumb_h &&
                 src_col == pick_col && next_x < thumb_w) begin
      thumb.pixel  = px;
      thumb.column = COORD_W'(next_x);
      thumb.row    = COORD_W'(next_y);
      thumb.width  = SIDE_W'(thumb_w);
      thumb.height = SIDE_W'(thumb_h);
      thumb.done   = (next_x + 1 == thumb_w && next_y + 1 == thumb_h);
      thumb.status = STATUS_PIXEL;
      pending_thumb_px.push_back(thumb);
      next_x++;
      pick_col = nearest_src(next_x, frame_w, thumb_w);
    end
    src_col++;
    if (src_col >= frame_w) begin
      src_col = 0;
      if (!frame_bad && src_row == pick_row && next_y < thumb_h) begin
        next_y++;
        pick_row = nearest_src(next_y, frame_h, thumb_h);
        next_x = 0;
        pick_col = 0;
      end
      src_row++;
      if (src_row >= frame_h) begin
        src_row = 0;
        frame_open = 1'b0;
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      mismatches++;
    end
  endtask

  // monitor: outputs first, then register writes and pixel transfers
  always @(posedge clk) begin
    thumb_px_t want;
    in_fire = in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_thumb_px.size() == 0) begin
          $error("unexpected output transfer: pixel %0h column %0d row %0d",
                 out_pixel, out_column, out_row);
          mismatches++;
        end else begin
          want = pending_thumb_px.pop_front();
          check_field("out_pixel", want.pixel, out_pixel);
          check_field("out_column", 32'(want.column), 32'(out_column));
          check_field("out_row", 32'(want.row), 32'(out_row));
          check_field("out_thumb_width", 32'(want.width), 32'(out_thumb_width));
          check_field("out_thumb_height", 32'(want.height), 32'(out_thumb_height));
          check_field("out_frame_done", 32'(want.done), 32'(out_frame_done));
          check_field("out_status", 32'(want.status), 32'(out_status));
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_fire) select_pixel(in_pixel);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (src_pixels.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_pixel <= src_pixels.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic push_random(int unsigned n);
    for (int i = 0; i < n; i++) src_pixels.push_back($urandom);
  endtask

  // wait until the sender is empty, all results are in, and the block has settled
  task automatic drain_block();
    @(posedge clk);
    while (src_pixels.size() != 0 || in_valid || pending_thumb_px.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes need no gap
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DAT_W-1:0] with_noise(int unsigned v, bit noisy);
    return CFG_DAT_W'(v) | (noisy ? (CFG_DAT_W'($urandom) & UPPER_BITS) : '0);
  endfunction

  task automatic set_frame(int unsigned sw, sh, me, mb, bit noisy);
    write_reg(REG_SOURCE_WIDTH, with_noise(sw, noisy));
    write_reg(REG_SOURCE_HEIGHT, with_noise(sh, noisy));
    write_reg(REG_MAX_EDGE, with_noise(me, noisy));
    write_reg(REG_MAX_BYTES, CFG_DAT_W'(mb));
    end_writes();
  endtask

  initial begin
    int unsigned sw, sh, me, mb, nfr, npx, kind, rand_items;
    rand_items = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: empty sides, so each pixel is rejected on its own
    src_pixels.push_back('0);
    src_pixels.push_back('1);
    drain_block();

    // no scaling needed
    set_frame(3, 2, 256, 262144, 1'b0);
    src_pixels.push_back('0);
    src_pixels.push_back('1);
    push_random(4);
    drain_block();

    // short side rounds to zero and is clamped to one
    set_frame(5, 1, 1, MAX_BYTES_CFG, 1'b0);
    push_random(5);
    drain_block();

    // zero edge limit rejects; error only on the first pixel
    set_frame(1, 2, 0, MAX_BYTES_CFG, 1'b0);
    push_random(2);
    drain_block();

    // byte limit exactly met, then one byte short
    set_frame(2, 1, 8, 8, 1'b0);
    push_random(2);
    drain_block();
    write_reg(REG_MAX_BYTES, CFG_DAT_W'(7));
    end_writes();
    push_random(2);
    drain_block();

    // source side above the maximum
    set_frame(5000, 1, 4096, MAX_BYTES_CFG, 1'b0);
    push_random(1);
    drain_block();

    // unknown register index mid-frame leaves the frame running
    set_frame(3, 3, 2, MAX_BYTES_CFG, 1'b0);
    push_random(4);
    drain_block();
    write_reg(BAD_REG_IDX, CFG_DAT_W'($urandom));
    end_writes();
    push_random(5);
    drain_block();

    // a real register write abandons the frame in progress
    set_frame(2, 2, 256, MAX_BYTES_CFG, 1'b0);
    push_random(1);
    drain_block();
    write_reg(REG_SOURCE_HEIGHT, CFG_DAT_W'(3));
    end_writes();
    push_random(6);
    drain_block();

    // full-size row and column, cut short by the next setup; no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_frame(4096, 1, 4096, MAX_BYTES_CFG, 1'b0);
    push_random(LONG_RUN_PX);
    drain_block();
    set_frame(1, 4096, 4096, MAX_BYTES_CFG, 1'b0);
    push_random(LONG_RUN_PX);
    drain_block();

    // receiver holds off while the sender keeps going: block backs up
    set_frame(20, 20, 64, MAX_BYTES_CFG, 1'b0);
    hold_req++;
    push_random(400);
    drain_block();
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;

    // largest source scaled to exactly the byte limit, then just over it
    set_frame(4096, 4096, 256, 262144, 1'b0);
    push_random(64);
    drain_block();
    write_reg(REG_MAX_BYTES, CFG_DAT_W'(262143));
    end_writes();
    push_random(3);
    drain_block();

    while (rand_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        sw = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
        sh = (sw == 0) ? $urandom_range(0, 12) : 0;
        set_frame(sw, sh, $urandom_range(0, 4096), $urandom_range(0, MAX_BYTES_CFG),
                  1'($urandom_range(0, 1)));
        npx = $urandom_range(1, 3);
        push_random(npx);
        rand_items += npx;
      end else if (kind < 12) begin
        // big source, cut off after part of the first row
        set_frame($urandom_range(1024, 4096), $urandom_range(1024, 4096),
                  $urandom_range(1, 300), MAX_BYTES_CFG, 1'($urandom_range(0, 1)));
        npx = $urandom_range(20, 80);
        push_random(npx);
        rand_items += npx;
      end else begin
        sw = $urandom_range(1, 12);
        sh = $urandom_range(1, 12);
        me = $urandom_range(0, 14);
        mb = (kind < 24) ? $urandom_range(0, sw * sh * 4 + 8)
                         : $urandom_range(sw * sh * 4, MAX_BYTES_CFG);
        set_frame(sw, sh, me, mb, 1'($urandom_range(0, 1)));
        nfr = $urandom_range(1, 3);
        npx = nfr * sw * sh;
        if ($urandom_range(0, 4) == 0) npx = $urandom_range(1, npx);
        push_random(npx);
        rand_items += npx;
      end
      drain_block();
    end

    drain_block();
    if (mismatches == 0 && pending_thumb_px.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
